>>> sv/hmng_pkg.sv
// Shared types, constants and defaults of the heightmap normal generator.
package hmng_pkg;

  localparam int unsigned MAX_SIDE_DEF = 1024;

  localparam int unsigned SIDE_W   = 11;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned HEIGHT_W = 8;
  localparam int unsigned COORD_W  = 10;
  localparam int unsigned NORM_W   = 16;
  localparam int unsigned DIFF_W   = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_SCALE   = 2'd2;

  localparam logic [SIDE_W-1:0]  SIDE_RST  = 11'd256;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;

  // Q1.14 one.
  localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dr;
    logic signed [DIFF_W-1:0] dc;
  } hmng_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
  } hmng_rsp_t;

endpackage

>>> sv/hmng_if.sv
// Valid/ready channel interfaces for height samples and normal results.
interface hmng_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface hmng_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         row;
  logic [9:0]         col;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               run_end;

  modport source (output valid, output row, output col, output normal_x, output normal_y,
                  output normal_z, output run_end, input ready);
  modport sink (input valid, input row, input col, input normal_x, input normal_y,
                input normal_z, input run_end, output ready);
endinterface

>>> sv/hmng_ram.sv
// Generic single write port, single read port RAM with registered read data.
module hmng_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/hmng_norm.sv
// Iterative normalizer: one shared 32x32 multiplier under a small sequencer.
module hmng_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  hmng_pkg::hmng_req_t            req,
  input  logic [hmng_pkg::SCALE_W-1:0]   grid_scale,
  input  logic [hmng_pkg::SCALE_W-1:0]   vert_scale,
  output hmng_pkg::hmng_rsp_t            rsp
);
  import hmng_pkg::*;

  typedef enum logic [10:0] {
    N_IDLE = 11'b00000000001,
    N_MX   = 11'b00000000010,
    N_MZ   = 11'b00000000100,
    N_CHK  = 11'b00000001000,
    N_SQX  = 11'b00000010000,
    N_SQY  = 11'b00000100000,
    N_SQZ  = 11'b00001000000,
    N_LIM  = 11'b00010000000,
    N_T1   = 11'b00100000000,
    N_T2   = 11'b01000000000,
    N_T3   = 11'b10000000000
  } nstate_t;

  nstate_t state;
  logic [DIFF_W-1:0] dr_mag;
  logic [DIFF_W-1:0] dc_mag;
  logic        neg_x;
  logic        neg_z;
  logic [23:0] mx;
  logic [23:0] my;
  logic [23:0] mz;
  logic [31:0] s;
  logic [29:0] m2;
  logic [31:0] tt;
  logic [63:0] ts;
  logic [14:0] q;
  logic [3:0]  bitpos;
  logic [1:0]  comp;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [14:0] m_sel;
  logic [14:0] cand;
  logic [15:0] t;
  logic [14:0] q_fin;
  logic signed [NORM_W-1:0] q_pos;
  logic signed [NORM_W-1:0] q_neg;

  always_comb begin
    case (comp)
      2'd0:    m_sel = mx[14:0];
      2'd1:    m_sel = my[14:0];
      default: m_sel = mz[14:0];
    endcase
    cand  = q | (15'd1 << bitpos);
    t     = {cand, 1'b0} - 16'd1;
    q_fin = (ts <= {4'd0, m2, 30'd0}) ? cand : q;
    q_pos = NORM_W'(q_fin);
    q_neg = -q_pos;
  end

  always_comb begin
    unique case (state)
      N_MX:    begin mul_a = 32'(vert_scale); mul_b = 32'(dr_mag); end
      N_MZ:    begin mul_a = 32'(vert_scale); mul_b = 32'(dc_mag); end
      N_SQX:   begin mul_a = 32'(mx); mul_b = 32'(mx); end
      N_SQY:   begin mul_a = 32'(my); mul_b = 32'(my); end
      N_SQZ:   begin mul_a = 32'(mz); mul_b = 32'(mz); end
      N_LIM:   begin mul_a = 32'(m_sel); mul_b = 32'(m_sel); end
      N_T1:    begin mul_a = 32'(t); mul_b = 32'(t); end
      N_T2:    begin mul_a = tt; mul_b = s; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= N_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        N_IDLE: begin
          if (req.start) begin
            dr_mag <= req.dr[DIFF_W-1] ? (DIFF_W'(0) - req.dr) : req.dr;
            dc_mag <= req.dc[DIFF_W-1] ? (DIFF_W'(0) - req.dc) : req.dc;
            neg_x  <= !req.dr[DIFF_W-1] && (req.dr != '0);
            neg_z  <= !req.dc[DIFF_W-1] && (req.dc != '0);
            state  <= N_MX;
          end
        end
        N_MX: begin
          mx    <= prod[23:0];
          state <= N_MZ;
        end
        N_MZ: begin
          mz    <= prod[23:0];
          my    <= 24'(grid_scale);
          state <= N_CHK;
        end
        N_CHK: begin
          if ((mx | my | mz) == '0) begin
            rsp.nx   <= '0;
            rsp.ny   <= NORM_ONE;
            rsp.nz   <= '0;
            rsp.done <= 1'b1;
            state    <= N_IDLE;
          end else if ((mx[23:15] | my[23:15] | mz[23:15]) != '0) begin
            mx <= mx >> 1;
            my <= my >> 1;
            mz <= mz >> 1;
          end else begin
            state <= N_SQX;
          end
        end
        N_SQX: begin
          s     <= prod[31:0];
          state <= N_SQY;
        end
        N_SQY: begin
          s     <= s + prod[31:0];
          state <= N_SQZ;
        end
        N_SQZ: begin
          s     <= s + prod[31:0];
          comp  <= 2'd0;
          state <= N_LIM;
        end
        N_LIM: begin
          m2     <= prod[29:0];
          q      <= '0;
          bitpos <= 4'd14;
          state  <= N_T1;
        end
        N_T1: begin
          tt    <= prod[31:0];
          state <= N_T2;
        end
        N_T2: begin
          ts    <= prod;
          state <= N_T3;
        end
        N_T3: begin
          q <= q_fin;
          if (bitpos != 4'd0) begin
            bitpos <= bitpos - 4'd1;
            state  <= N_T1;
          end else begin
            case (comp)
              2'd0:    rsp.nx <= neg_x ? q_neg : q_pos;
              2'd1:    rsp.ny <= q_pos;
              default: rsp.nz <= neg_z ? q_neg : q_pos;
            endcase
            if (comp == 2'd2) begin
              rsp.done <= 1'b1;
              state    <= N_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_LIM;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end
endmodule

>>> sv/heightmap_normal_generator_top.sv
// Heightmap normal generator: line stores, read sequencer and result output register.
// Sequence: a row 0 item gives no result. Otherwise the item is taken, the line store is read,
// the normalizer runs (with up to nine shift steps, none for a zero vector) and the first result
// is loaded; each further result of the item is normalized and loaded in turn.
// Intake: one item per cycle on row 0, else a new item only after the last result is loaded.
// Reset: side and both scales return to 256, counters clear; the line store is not cleared.
module heightmap_normal_generator_top #(
  parameter int unsigned MAX_SIDE = hmng_pkg::MAX_SIDE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  hmng_in_if.sink                           pix,
  hmng_out_if.source                        res,
  input  logic                              cfg_we,
  input  logic [hmng_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hmng_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hmng_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned NW = $clog2(MAX_SIDE + 1);
  localparam int unsigned AW = $clog2(2 * MAX_SIDE);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_RD0   = 8'b00000010,
    ST_RD1   = 8'b00000100,
    ST_RD2   = 8'b00001000,
    ST_RD3   = 8'b00010000,
    ST_START = 8'b00100000,
    ST_WAIT  = 8'b01000000,
    ST_LOAD  = 8'b10000000
  } state_t;

  typedef enum logic [1:0] {
    JOB_ABOVE,
    JOB_LEFT,
    JOB_HERE
  } job_t;

  state_t state;
  job_t   job;
  logic [SIDE_W-1:0]   side;
  logic [SCALE_W-1:0]  grid_scale;
  logic [SCALE_W-1:0]  vert_scale;
  logic [CW-1:0]       rcnt;
  logic [CW-1:0]       ccnt;
  logic [HEIGHT_W-1:0] prevh;
  logic [HEIGHT_W-1:0] h;
  logic [HEIGHT_W-1:0] prev_old;
  logic [HEIGHT_W-1:0] up;
  logic [HEIGHT_W-1:0] nb;
  logic [HEIGHT_W-1:0] lf;
  logic [CW-1:0]       rc;
  logic [CW-1:0]       cc;
  logic [NORM_W-1:0]   hold_x;
  logic [NORM_W-1:0]   hold_y;
  logic [NORM_W-1:0]   hold_z;
  logic [NW-1:0]       n_eff;
  logic [CW-1:0]       r_w;
  logic [CW-1:0]       c_w;
  logic [NW-1:0]       c_inc;
  logic [NW-1:0]       r_inc;
  logic                in_take;
  logic                last_row;
  logic                right_ok;
  logic                more;
  logic [CW-1:0]       nb_col;
  logic [CW-1:0]       lf_col;
  logic [CW-1:0]       rd_col;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [HEIGHT_W-1:0] rdata;
  logic signed [DIFF_W-1:0] d_hu;
  logic signed [DIFF_W-1:0] d_hp;
  hmng_req_t nreq;
  hmng_rsp_t nrsp;

  always_comb begin
    if (side < SIDE_W'(2)) begin
      n_eff = NW'(2);
    end else if (32'(side) > 32'(MAX_SIDE)) begin
      n_eff = NW'(MAX_SIDE);
    end else begin
      n_eff = NW'(side);
    end
  end

  assign in_take   = pix.valid && pix.ready;
  assign pix.ready = (state == ST_IDLE);

  always_comb begin
    if (NW'(rcnt) >= n_eff || NW'(ccnt) >= n_eff) begin
      r_w = '0;
      c_w = '0;
    end else begin
      r_w = rcnt;
      c_w = ccnt;
    end
    c_inc = NW'(c_w) + NW'(1);
    r_inc = NW'(r_w) + NW'(1);
    waddr = r_w[0] ? (AW'(MAX_SIDE) + AW'(c_w)) : AW'(c_w);
  end

  assign last_row = (NW'(rc) == n_eff - NW'(1));
  assign right_ok = (NW'(cc) + NW'(1) < n_eff);
  assign lf_col   = (cc == '0) ? '0 : cc - CW'(1);
  assign nb_col   = right_ok ? cc + CW'(1) : lf_col;

  always_comb begin
    case (state)
      ST_RD0:  rd_col = cc;
      ST_RD1:  rd_col = nb_col;
      default: rd_col = lf_col;
    endcase
    // Row r-1 sits in the bank of opposite parity.
    raddr = rc[0] ? AW'(rd_col) : (AW'(MAX_SIDE) + AW'(rd_col));
  end

  hmng_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (2 * MAX_SIDE)
  ) u_line (
    .clk   (clk),
    .we    (in_take),
    .waddr (waddr),
    .wdata (pix.height),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign d_hu = DIFF_W'(h) - DIFF_W'(up);
  assign d_hp = DIFF_W'(h) - DIFF_W'(prev_old);

  always_comb begin
    nreq.start = (state == ST_START);
    case (job)
      JOB_ABOVE: begin
        nreq.dr = d_hu;
        nreq.dc = right_ok ? (DIFF_W'(nb) - DIFF_W'(up)) : (DIFF_W'(up) - DIFF_W'(nb));
      end
      JOB_LEFT: begin
        nreq.dr = DIFF_W'(prev_old) - DIFF_W'(lf);
        nreq.dc = d_hp;
      end
      default: begin
        nreq.dr = d_hu;
        nreq.dc = d_hp;
      end
    endcase
    case (job)
      JOB_ABOVE: more = last_row && (cc != '0);
      JOB_LEFT:  more = (NW'(cc) == n_eff - NW'(1));
      default:   more = 1'b0;
    endcase
  end

  hmng_norm u_norm (
    .clk        (clk),
    .rst        (rst),
    .req        (nreq),
    .grid_scale (grid_scale),
    .vert_scale (vert_scale),
    .rsp        (nrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      side         <= SIDE_RST;
      grid_scale   <= SCALE_RST;
      vert_scale   <= SCALE_RST;
      rcnt         <= '0;
      ccnt         <= '0;
      prevh        <= '0;
      res.valid    <= 1'b0;
      job          <= JOB_ABOVE;
    end else begin
      // In the load state the output register is refilled instead.
      if (res.valid && res.ready && state != ST_LOAD) begin
        res.valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SIDE: begin
            side <= cfg_data[SIDE_W-1:0];
            rcnt <= '0;
            ccnt <= '0;
          end
          CFG_GRID_SCALE: grid_scale <= cfg_data;
          CFG_VERT_SCALE: vert_scale <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            h        <= pix.height;
            prev_old <= prevh;
            prevh    <= pix.height;
            rc       <= r_w;
            cc       <= c_w;
            job      <= JOB_ABOVE;
            if (c_inc >= n_eff) begin
              ccnt <= '0;
              rcnt <= (r_inc >= n_eff) ? '0 : CW'(r_inc);
            end else begin
              ccnt <= CW'(c_inc);
              rcnt <= r_w;
            end
            if (r_w != '0) begin
              state <= ST_RD0;
            end
          end
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          up    <= rdata;
          state <= ST_RD2;
        end
        ST_RD2: begin
          nb    <= rdata;
          state <= ST_RD3;
        end
        ST_RD3: begin
          lf    <= rdata;
          state <= ST_START;
        end
        ST_START: state <= ST_WAIT;
        ST_WAIT: begin
          if (nrsp.done) begin
            hold_x <= nrsp.nx;
            hold_y <= nrsp.ny;
            hold_z <= nrsp.nz;
            state  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (!res.valid || res.ready) begin
            res.valid    <= 1'b1;
            res.normal_x <= hold_x;
            res.normal_y <= hold_y;
            res.normal_z <= hold_z;
            res.run_end  <= !more;
            case (job)
              JOB_ABOVE: begin
                res.row <= COORD_W'(rc - CW'(1));
                res.col <= COORD_W'(cc);
              end
              JOB_LEFT: begin
                res.row <= COORD_W'(rc);
                res.col <= COORD_W'(cc - CW'(1));
              end
              default: begin
                res.row <= COORD_W'(rc);
                res.col <= COORD_W'(cc);
              end
            endcase
            if (more) begin
              job   <= (job == JOB_ABOVE && !(NW'(cc) == n_eff - NW'(1)) ? JOB_LEFT
                        : (job == JOB_ABOVE ? JOB_LEFT : JOB_HERE));
              state <= ST_START;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (NW'(rcnt) < n_eff) && (NW'(ccnt) < n_eff))
    else $error("row or column counter outside the map");

  a_ny_pos: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !res.normal_y[NORM_W-1])
    else $error("vertical normal component negative");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    nrsp.done |-> (state == ST_WAIT))
    else $error("normalizer finished while no result was awaited");
`endif
endmodule
